// ===== sv/cst_pkg.sv =====
package cst_pkg;

   // default table geometry
   localparam int DEF_NUM_SEMS    = 16;
   localparam int DEF_QUEUE_DEPTH = 16;

   // fixed field widths
   localparam int MODE_W   = 2;
   localparam int ID_W     = 8;
   localparam int COUNT_W  = 16;
   localparam int PROC_W   = 8;
   localparam int STATUS_W = 2;
   localparam int ALLOC_W  = 4;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SIGNAL = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ID     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL = 2'd3;

   // count saturation limits
   localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;
   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7fff;

   // result flags produced by the table controller
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ALLOC_W-1:0]  alloc_id;
      logic                block_caller;
      logic                wake_valid;
   } cst_result_type;

endpackage

// ===== sv/cst_waiter_ram.sv =====
module cst_waiter_ram
   import cst_pkg::*;
#(
   parameter int DEPTH  = DEF_NUM_SEMS * DEF_QUEUE_DEPTH,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [PROC_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [PROC_W-1:0] rd_data
);

   logic [PROC_W-1:0] mem_ff [DEPTH];
   logic [PROC_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/cst_ctrl.sv =====
module cst_ctrl
   import cst_pkg::*;
#(
   parameter int NUM_SEMS    = DEF_NUM_SEMS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int ADDR_W      = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic [MODE_W-1:0]         mode,
   input  logic [ID_W-1:0]           sem_id,
   input  logic signed [COUNT_W-1:0] init_value,
   input  logic [PROC_W-1:0]         proc_id,
   output cst_result_type            result,
   output logic                      ram_wr_en,
   output logic [ADDR_W-1:0]         ram_wr_addr,
   output logic [PROC_W-1:0]         ram_wr_data,
   output logic                      ram_rd_en,
   output logic [ADDR_W-1:0]         ram_rd_addr
);

   localparam int IDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int TOT_W = $clog2(QUEUE_DEPTH + 1);

   logic [NUM_SEMS-1:0]               valid_ff;
   logic signed [COUNT_W-1:0]         count_ff [NUM_SEMS];
   logic [PTR_W-1:0]                  head_ff  [NUM_SEMS];
   logic [PTR_W-1:0]                  tail_ff  [NUM_SEMS];
   logic [TOT_W-1:0]                  total_ff [NUM_SEMS];

   logic [IDX_W-1:0]          sel;
   logic                      id_ok;
   logic signed [COUNT_W-1:0] cur_count;
   logic [PTR_W-1:0]          cur_head;
   logic [PTR_W-1:0]          cur_tail;
   logic [TOT_W-1:0]          cur_total;
   logic signed [COUNT_W-1:0] wait_count;
   logic signed [COUNT_W-1:0] signal_count;
   logic                      free_found;
   logic [IDX_W-1:0]          free_idx;

   logic                      do_alloc;
   logic                      do_enqueue;
   logic                      do_dequeue;
   logic                      count_we;
   logic [IDX_W-1:0]          count_idx;
   logic signed [COUNT_W-1:0] count_in;
   logic [PTR_W-1:0]          head_in;
   logic [PTR_W-1:0]          tail_in;
   logic [TOT_W-1:0]          total_in;
   cst_result_type            res;

   assign sel       = sem_id[IDX_W-1:0];
   assign id_ok     = ({1'b0, sem_id} < 9'(NUM_SEMS)) && valid_ff[sel];
   assign cur_count = count_ff[sel];
   assign cur_head  = head_ff[sel];
   assign cur_tail  = tail_ff[sel];
   assign cur_total = total_ff[sel];

   assign wait_count   = (cur_count == COUNT_MIN) ? COUNT_MIN : cur_count - 16'sd1;
   assign signal_count = (cur_count == COUNT_MAX) ? COUNT_MAX : cur_count + 16'sd1;

   assign head_in  = (cur_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
   assign tail_in  = (cur_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_tail + 1'b1;

   // lowest free entry
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SEMS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      res        = '0;
      res.status = STATUS_OK;
      do_alloc   = 1'b0;
      do_enqueue = 1'b0;
      do_dequeue = 1'b0;
      count_we   = 1'b0;
      count_idx  = sel;
      count_in   = wait_count;
      total_in   = cur_total;
      unique case (mode)
         MODE_ALLOC: begin
            count_idx = free_idx;
            count_in  = init_value;
            if (free_found) begin
               do_alloc     = 1'b1;
               count_we     = 1'b1;
               res.alloc_id = ALLOC_W'(free_idx);
            end else begin
               res.status = STATUS_NO_FREE;
            end
         end
         MODE_WAIT: begin
            if (!id_ok) begin
               res.status = STATUS_BAD_ID;
            end else if (wait_count[COUNT_W-1]) begin
               if (cur_total == TOT_W'(QUEUE_DEPTH)) begin
                  res.status = STATUS_QUEUE_FULL;
               end else begin
                  // queue the caller; a saturated count still blocks
                  do_enqueue       = 1'b1;
                  count_we         = 1'b1;
                  total_in         = cur_total + 1'b1;
                  res.block_caller = 1'b1;
               end
            end else begin
               count_we = 1'b1;
            end
         end
         MODE_SIGNAL: begin
            count_in = signal_count;
            if (!id_ok) begin
               res.status = STATUS_BAD_ID;
            end else begin
               count_we = 1'b1;
               if (cur_total != '0) begin
                  do_dequeue     = 1'b1;
                  total_in       = cur_total - 1'b1;
                  res.wake_valid = 1'b1;
               end
            end
         end
         default: begin
            res.status = STATUS_BAD_ID;
         end
      endcase
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < NUM_SEMS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            total_ff[i] <= '0;
         end
      end else if (fire) begin
         if (do_alloc) begin
            valid_ff[free_idx] <= 1'b1;
            head_ff[free_idx]  <= '0;
            tail_ff[free_idx]  <= '0;
            total_ff[free_idx] <= '0;
         end
         if (do_enqueue) begin
            tail_ff[sel]  <= tail_in;
            total_ff[sel] <= total_in;
         end
         if (do_dequeue) begin
            head_ff[sel]  <= head_in;
            total_ff[sel] <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && count_we) begin
         count_ff[count_idx] <= count_in;
      end
   end

   assign ram_wr_en   = fire && do_enqueue;
   assign ram_wr_addr = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(cur_tail);
   assign ram_wr_data = proc_id;
   assign ram_rd_en   = fire && do_dequeue;
   assign ram_rd_addr = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(cur_head);

endmodule

// ===== sv/counting_semaphore_table.sv =====
// Semaphore table with a FIFO wait queue per entry.
//
// req channel: one operation per transaction. req_tuser carries the mode
// (allocate, wait, signal); req_tdata carries sem_id, init_value, proc_id.
// rsp channel: exactly one result per operation, in order: status,
// alloc_id, block_caller, wake_valid, wake_proc.
//
// Flow: a transaction accepted on req lands in the input register, is
// decided and written back when it fires (together with the waiter RAM
// read/write) into the result register, and is offered on rsp from there.
// Throughput: one operation per cycle while rsp_tready is not stalling
// the result register; every operation is a single read-modify-write of
// one table entry plus a priority encode over the valid bits for allocate,
// and the waiter RAM sees at most one access per cycle.
//
// Reset marks every entry free and empties every queue. When rsp_tready
// is low the result register holds, the input register holds one more
// operation, and req_tready drops once both are full.
module counting_semaphore_table
   import cst_pkg::*;
#(
   parameter int NUM_SEMS    = DEF_NUM_SEMS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sem_id[7:0], init_value[23:8], proc_id[31:24]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[1:0], alloc_id[5:2], block_caller[6],
                                    // wake_valid[7], wake_proc[15:8]
);

   localparam int RAM_DEPTH = NUM_SEMS * QUEUE_DEPTH;
   localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   logic                      in_valid_ff;
   logic [MODE_W-1:0]         mode_ff;
   logic [ID_W-1:0]           sem_id_ff;
   logic signed [COUNT_W-1:0] init_value_ff;
   logic [PROC_W-1:0]         proc_id_ff;

   logic                      out_valid_ff;
   cst_result_type            result_ff;

   logic                      fire;
   cst_result_type            result;
   logic                      ram_wr_en;
   logic [ADDR_W-1:0]         ram_wr_addr;
   logic [PROC_W-1:0]         ram_wr_data;
   logic                      ram_rd_en;
   logic [ADDR_W-1:0]         ram_rd_addr;
   logic [PROC_W-1:0]         ram_rd_data;
   logic [PROC_W-1:0]         wake_proc;

   // advance the held operation when the result register is free or draining
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         mode_ff       <= req_tuser;
         sem_id_ff     <= req_tdata[7:0];
         init_value_ff <= req_tdata[23:8];
         proc_id_ff    <= req_tdata[31:24];
      end
   end

   cst_ctrl #(
      .NUM_SEMS    (NUM_SEMS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .mode        (mode_ff),
      .sem_id      (sem_id_ff),
      .init_value  (init_value_ff),
      .proc_id     (proc_id_ff),
      .result      (result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr)
   );

   cst_waiter_ram #(
      .DEPTH  (RAM_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_waiter_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result;
      end
   end

   // the RAM read register only loads on a dequeue, so mask it otherwise
   assign wake_proc  = result_ff.wake_valid ? ram_rd_data : '0;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {wake_proc, result_ff.wake_valid, result_ff.block_caller,
                        result_ff.alloc_id, result_ff.status};

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(result_ff.block_caller && result_ff.wake_valid))
      else $error("block and wake flagged on the same result");

   a_error_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result_ff.status != STATUS_OK) |->
         (!result_ff.block_caller && !result_ff.wake_valid && result_ff.alloc_id == '0))
      else $error("failed operation carries side flags");

   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(mode_ff) && $stable(sem_id_ff)))
      else $error("held operation lost while the result register is stalled");

   a_ram_single : assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("waiter RAM written and read in one cycle");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import cst_pkg::*;

   localparam int NUM_SEMS    = DEF_NUM_SEMS;
   localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
   localparam int IDLE_LIMIT  = 1000;
   localparam int MAX_REPORTS = 10;

   // mode 3 is not an operation; the block answers it with a bad id
   localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;

   // laid out MSB first so that it matches rsp_tdata bit for bit
   typedef struct packed {
      logic [PROC_W-1:0]   wake_proc;
      logic                wake_valid;
      logic                block_caller;
      logic [ALLOC_W-1:0]  alloc_id;
      logic [STATUS_W-1:0] status;
   } sem_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // sem_id[7:0], init_value[23:8], proc_id[31:24]
   logic [1:0]  req_tuser;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // status[1:0], alloc_id[5:2], block_caller[6],
                             // wake_valid[7], wake_proc[15:8]

   // shadow of the semaphore table
   bit                        sem_live [NUM_SEMS];
   logic signed [COUNT_W-1:0] sem_level [NUM_SEMS];
   logic [PROC_W-1:0]         waiter_ram [NUM_SEMS][QUEUE_DEPTH];
   int unsigned               q_head [NUM_SEMS];
   int unsigned               q_tail [NUM_SEMS];
   int unsigned               q_len [NUM_SEMS];

   sem_result_type pending_results[$];

   bit no_gaps = 1'b0;
   int fail_count = 0;
   int idle_cycles = 0;
   int ops_sent = 0;
   int results_seen = 0;
   int blocked_waits = 0;
   int wakeups = 0;
   int full_refusals = 0;
   int nofree_refusals = 0;
   int badid_refusals = 0;

   counting_semaphore_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Apply one operation to the shadow table and return what the block must answer.
   function automatic sem_result_type apply_semaphore_op(logic [MODE_W-1:0] op,
         logic [ID_W-1:0] id, logic signed [COUNT_W-1:0] init, logic [PROC_W-1:0] proc);
      sem_result_type r;
      int slot;
      int level;
      r = '0;
      r.status = STATUS_OK;
      if (op == MODE_ALLOC) begin
         slot = -1;
         for (int s = NUM_SEMS - 1; s >= 0; s--)
            if (!sem_live[s]) slot = s;
         if (slot < 0) begin
            r.status = STATUS_NO_FREE;
         end else begin
            sem_live[slot]  = 1'b1;
            sem_level[slot] = init;
            q_head[slot]    = 0;
            q_tail[slot]    = 0;
            q_len[slot]     = 0;
            r.alloc_id      = slot[ALLOC_W-1:0];
         end
      end else if (op == MODE_UNKNOWN || id >= NUM_SEMS || !sem_live[id]) begin
         r.status = STATUS_BAD_ID;
      end else if (op == MODE_WAIT) begin
         level = int'(sem_level[id]) - 1;
         if (level < int'(COUNT_MIN)) level = int'(COUNT_MIN);
         if (level < 0) begin
            if (q_len[id] >= QUEUE_DEPTH) begin
               r.status = STATUS_QUEUE_FULL;
            end else begin
               waiter_ram[id][q_tail[id]] = proc;
               q_tail[id] = (q_tail[id] + 1) % QUEUE_DEPTH;
               q_len[id]++;
               sem_level[id] = level[COUNT_W-1:0];
               r.block_caller = 1'b1;
            end
         end else begin
            sem_level[id] = level[COUNT_W-1:0];
         end
      end else begin
         level = int'(sem_level[id]) + 1;
         if (level > int'(COUNT_MAX)) level = int'(COUNT_MAX);
         sem_level[id] = level[COUNT_W-1:0];
         if (q_len[id] > 0) begin
            r.wake_proc  = waiter_ram[id][q_head[id]];
            r.wake_valid = 1'b1;
            q_head[id] = (q_head[id] + 1) % QUEUE_DEPTH;
            q_len[id]--;
         end
      end
      return r;
   endfunction

   // Send one operation; valid drops only when a gap is drawn.
   task automatic send_sem_op(input logic [MODE_W-1:0] op, input logic [ID_W-1:0] id,
         input logic [COUNT_W-1:0] init, input logic [PROC_W-1:0] proc);
      int gap;
      gap = no_gaps ? 0 : int'($urandom_range(0, 15));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {proc, init, id};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_semaphore_op(op, id, init, proc));
      ops_sent++;
   endtask

   task automatic await_all_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_basic_ops();
      // operations on entries that were never allocated, and the unknown mode
      send_sem_op(MODE_WAIT, 8'd0, 16'd0, 8'h11);
      send_sem_op(MODE_SIGNAL, 8'd16, 16'd0, 8'h00);
      send_sem_op(MODE_UNKNOWN, 8'd0, 16'hffff, 8'hff);
      // entries 0..3 with the count extremes
      send_sem_op(MODE_ALLOC, 8'hff, 16'h7fff, 8'h00);
      send_sem_op(MODE_ALLOC, 8'h00, 16'h8000, 8'hff);
      send_sem_op(MODE_ALLOC, 8'h00, 16'h0000, 8'h00);
      send_sem_op(MODE_ALLOC, 8'h00, 16'h0001, 8'h00);
      // saturate up, then saturate down while still queueing the caller
      send_sem_op(MODE_SIGNAL, 8'd0, 16'h0000, 8'h00);
      send_sem_op(MODE_WAIT, 8'd1, 16'h0000, 8'hff);
      send_sem_op(MODE_SIGNAL, 8'd1, 16'h0000, 8'h00);
      send_sem_op(MODE_WAIT, 8'd2, 16'h0000, 8'h00);
      send_sem_op(MODE_WAIT, 8'd3, 16'h0000, 8'h33);
      send_sem_op(MODE_WAIT, 8'd3, 16'h0000, 8'ha5);
      send_sem_op(MODE_WAIT, 8'd255, 16'h0000, 8'h5a);
      send_sem_op(MODE_UNKNOWN, 8'd3, 16'h0000, 8'h00);
      send_sem_op(MODE_SIGNAL, 8'd3, 16'h0000, 8'h00);
      send_sem_op(MODE_SIGNAL, 8'd2, 16'h0000, 8'h00);
      send_sem_op(MODE_SIGNAL, 8'd15, 16'h0000, 8'h00);
   endtask

   // Take every free entry with a small count, then run into a full table.
   task automatic test_fill_table();
      int init;
      repeat (NUM_SEMS + 2) begin
         init = int'($urandom_range(0, 8)) - 4;
         send_sem_op(MODE_ALLOC, ID_W'($urandom()), init[COUNT_W-1:0], PROC_W'($urandom()));
      end
   endtask

   task automatic test_drain_pause();
      await_all_results();
      send_sem_op(MODE_WAIT, ID_W'($urandom_range(0, NUM_SEMS - 1)), COUNT_W'($urandom()),
         PROC_W'($urandom()));
   endtask

   // Phases lean on one entry: wait-heavy phases fill its queue, signal-heavy ones drain it.
   task automatic test_random_traffic();
      int hot_id;
      int wait_pct;
      logic [MODE_W-1:0] op;
      logic [ID_W-1:0] id;
      for (int phase = 0; phase < 20; phase++) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         hot_id = int'($urandom_range(0, NUM_SEMS - 1));
         case (phase % 3)
            0: begin
               wait_pct = 85;
            end
            1: begin
               wait_pct = 50;
            end
            default: begin
               wait_pct = 15;
            end
         endcase
         for (int n = 0; n < 51; n++) begin
            if ($urandom_range(0, 99) < 8) begin
               op = MODE_W'($urandom_range(0, 3));
               id = ID_W'($urandom_range(0, 255));
            end else begin
               op = ($urandom_range(0, 99) < wait_pct) ? MODE_WAIT : MODE_SIGNAL;
               id = ($urandom_range(0, 99) < 70) ? ID_W'(hot_id) :
                    ID_W'($urandom_range(0, NUM_SEMS - 1));
            end
            send_sem_op(op, id, COUNT_W'($urandom()), PROC_W'($urandom()));
         end
         if (phase % 5 == 4) await_all_results();
      end
      no_gaps = 1'b0;
   endtask

   // result side: stall before each transaction
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_gaps ? 0 : int'($urandom_range(0, 15));
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   always @(posedge clock) begin
      sem_result_type got;
      sem_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_seen++;
         if (pending_results.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("unexpected result %h with nothing outstanding", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.alloc_id !== want.alloc_id ||
                  got.block_caller !== want.block_caller ||
                  got.wake_valid !== want.wake_valid || got.wake_proc !== want.wake_proc) begin
               if (fail_count < MAX_REPORTS) begin
                  $display("result %0d: expected status=%0d alloc=%0d block=%0b wake=%0b proc=%h",
                     results_seen, want.status, want.alloc_id, want.block_caller,
                     want.wake_valid, want.wake_proc);
                  $display("result %0d: got      status=%0d alloc=%0d block=%0b wake=%0b proc=%h",
                     results_seen, got.status, got.alloc_id, got.block_caller,
                     got.wake_valid, got.wake_proc);
               end
               fail_count++;
            end
            if (want.block_caller) blocked_waits++;
            if (want.wake_valid) wakeups++;
            if (want.status == STATUS_QUEUE_FULL) full_refusals++;
            if (want.status == STATUS_NO_FREE) nofree_refusals++;
            if (want.status == STATUS_BAD_ID) badid_refusals++;
         end
      end
   end

   // watchdog: cycles without any transaction on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles, %0d results outstanding",
            idle_cycles, pending_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= '0;
      req_tdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_fill_table();
      test_drain_pause();
      test_random_traffic();

      await_all_results();
      repeat (10) @(posedge clock);

      $display("Ran %0d operations: %0d callers blocked, %0d woken, %0d refused on a full queue",
         ops_sent, blocked_waits, wakeups, full_refusals);
      $display("Refusals: %0d on a full table, %0d on a bad id or mode; %0d mismatches",
         nofree_refusals, badid_refusals, fail_count);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
